// File: hw/rtl/ipv4lpm_pkg.sv
// Shared types and constants for the IPv4 forwarding decision core.
// Used by ipv4lpm_cell and ipv4_forward_decision_lpm_core; no dependencies.
`timescale 1ns / 1ps

package ipv4lpm_pkg;

    localparam int ROUTE_SLOTS_DEFAULT = 16;
    localparam int PORT_COUNT_DEFAULT  = 4;

    localparam logic [3:0] IP_VERSION_4     = 4'd4;
    localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;
    localparam logic [7:0] TTL_EXPIRED_MAX  = 8'd1;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic CMD_ROUTE_WRITE = 1'b0;
    localparam logic CMD_PACKET      = 1'b1;

    localparam logic [2:0] CFG_IDX_PORTS_IN_USE = 3'd4;

    localparam logic [2:0] ACT_WRITTEN       = 3'd0;
    localparam logic [2:0] ACT_BAD_HEADER    = 3'd1;
    localparam logic [2:0] ACT_LOCAL_ICMP    = 3'd2;
    localparam logic [2:0] ACT_PORT_UNREACH  = 3'd3;
    localparam logic [2:0] ACT_UNKNOWN_PROTO = 3'd4;
    localparam logic [2:0] ACT_TIME_EXCEEDED = 3'd5;
    localparam logic [2:0] ACT_NET_UNREACH   = 3'd6;
    localparam logic [2:0] ACT_FORWARD       = 3'd7;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [1:0]  port;
    } t_route_entry;

    typedef struct packed {
        logic        active;
        logic [31:0] dst;
        logic        found;
        logic [31:0] best_mask;
        logic [31:0] gateway;
        logic [1:0]  port;
    } t_token;

endpackage

// File: hw/rtl/ipv4_forward_decision_lpm_core.sv
// IPv4 forwarding decision core: header checks, local address classing and a
// longest-prefix match over a chain of ipv4lpm_cell slots. Uses ipv4lpm_pkg.
// o_done rises the cycle after acceptance if no lookup is needed; a lookup
// walks the registered cells first. One request per cycle is taken when idle;
// busy is high while the token walks the chain. The receiver cannot stall.
// Reset clears the route valid bits, configuration registers and control.
`timescale 1ns / 1ps

module ipv4_forward_decision_lpm_core #(
    parameter int ROUTE_SLOTS = ipv4lpm_pkg::ROUTE_SLOTS_DEFAULT,
    parameter int PORT_COUNT  = ipv4lpm_pkg::PORT_COUNT_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_cmd,
    input  logic [3:0]  i_entry_slot,
    input  logic [31:0] i_entry_dest,
    input  logic [31:0] i_entry_mask,
    input  logic [31:0] i_entry_gateway,
    input  logic [1:0]  i_entry_port,
    input  logic        i_entry_valid,
    input  logic [3:0]  i_pkt_version,
    input  logic [3:0]  i_pkt_header_words,
    input  logic [7:0]  i_pkt_ttl,
    input  logic [7:0]  i_pkt_protocol,
    input  logic [31:0] i_pkt_dst,
    output logic        o_done,
    output logic [2:0]  o_action,
    output logic [7:0]  o_new_ttl,
    output logic [31:0] o_next_hop,
    output logic [1:0]  o_out_port
);

    logic [31:0]               r_if_ip [PORT_COUNT];
    logic [2:0]                r_ports_in_use;
    ipv4lpm_pkg::t_state       r_state;
    ipv4lpm_pkg::t_state       n_state;
    logic                      r_done;
    logic                      n_done;
    logic [2:0]                r_action;
    logic [2:0]                n_action;
    logic [7:0]                r_new_ttl;
    logic [7:0]                n_new_ttl;
    logic [31:0]               r_next_hop;
    logic [31:0]               n_next_hop;
    logic [1:0]                r_out_port;
    logic [1:0]                n_out_port;
    logic [7:0]                r_ttl_dec;
    logic [7:0]                n_ttl_dec;

    logic                      w_accept;
    logic                      w_bad_header;
    logic                      w_local;
    logic [2:0]                w_used;
    logic                      w_lookup;
    ipv4lpm_pkg::t_route_entry w_entry;
    ipv4lpm_pkg::t_token       w_inject;
    ipv4lpm_pkg::t_token       w_chain [ROUTE_SLOTS];
    ipv4lpm_pkg::t_token       w_tail;

    assign w_accept = start && !busy;
    assign busy     = (r_state == ipv4lpm_pkg::ST_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_if_ip[p] <= 32'd0;
            end
            r_ports_in_use <= 3'd0;
        end else if (i_cfg_we) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                if (i_cfg_index == 3'(p)) begin
                    r_if_ip[p] <= i_cfg_data;
                end
            end
            if (i_cfg_index == ipv4lpm_pkg::CFG_IDX_PORTS_IN_USE) begin
                r_ports_in_use <= i_cfg_data[2:0];
            end
        end
    end

    assign w_used = (r_ports_in_use > 3'(PORT_COUNT)) ? 3'(PORT_COUNT) : r_ports_in_use;

    always_comb begin
        w_local = 1'b0;
        for (int p = 0; p < PORT_COUNT; p++) begin
            if ((3'(p) < w_used) && (r_if_ip[p] == i_pkt_dst)) begin
                w_local = 1'b1;
            end
        end
    end

    assign w_bad_header = (i_pkt_version != ipv4lpm_pkg::IP_VERSION_4)
                       || (i_pkt_header_words < ipv4lpm_pkg::MIN_HEADER_WORDS);

    assign w_lookup = (i_cmd == ipv4lpm_pkg::CMD_PACKET) && !w_bad_header && !w_local
                   && (i_pkt_ttl > ipv4lpm_pkg::TTL_EXPIRED_MAX);

    assign w_entry.valid   = i_entry_valid;
    assign w_entry.dest    = i_entry_dest;
    assign w_entry.mask    = i_entry_mask;
    assign w_entry.gateway = i_entry_gateway;
    assign w_entry.port    = i_entry_port;

    assign w_inject.active    = w_accept && w_lookup;
    assign w_inject.dst       = i_pkt_dst;
    assign w_inject.found     = 1'b0;
    assign w_inject.best_mask = 32'd0;
    assign w_inject.gateway   = 32'd0;
    assign w_inject.port      = 2'd0;

    genvar g;
    generate
        for (g = 0; g < ROUTE_SLOTS; g++) begin : g_cell
            ipv4lpm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr_en (w_accept && (i_cmd == ipv4lpm_pkg::CMD_ROUTE_WRITE)
                          && (32'(i_entry_slot) == 32'(g))),
                .i_entry (w_entry),
                .i_token ((g == 0) ? w_inject : w_chain[(g == 0) ? 0 : g - 1]),
                .o_token (w_chain[g])
            );
        end
    endgenerate

    assign w_tail = w_chain[ROUTE_SLOTS - 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv4lpm_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_new_ttl  <= n_new_ttl;
        r_next_hop <= n_next_hop;
        r_out_port <= n_out_port;
        r_ttl_dec  <= n_ttl_dec;
    end

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_action   = r_action;
        n_new_ttl  = r_new_ttl;
        n_next_hop = r_next_hop;
        n_out_port = r_out_port;
        n_ttl_dec  = r_ttl_dec;
        unique case (r_state)
            ipv4lpm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_new_ttl  = i_pkt_ttl;
                    n_next_hop = 32'd0;
                    n_out_port = 2'd0;
                    n_ttl_dec  = i_pkt_ttl - 8'd1;
                    if (i_cmd == ipv4lpm_pkg::CMD_ROUTE_WRITE) begin
                        n_done   = 1'b1;
                        n_action = ipv4lpm_pkg::ACT_WRITTEN;
                    end else if (w_bad_header) begin
                        n_done   = 1'b1;
                        n_action = ipv4lpm_pkg::ACT_BAD_HEADER;
                    end else if (w_local) begin
                        n_done = 1'b1;
                        if (i_pkt_protocol == ipv4lpm_pkg::PROTO_ICMP) begin
                            n_action = ipv4lpm_pkg::ACT_LOCAL_ICMP;
                        end else if ((i_pkt_protocol == ipv4lpm_pkg::PROTO_TCP)
                                  || (i_pkt_protocol == ipv4lpm_pkg::PROTO_UDP)) begin
                            n_action = ipv4lpm_pkg::ACT_PORT_UNREACH;
                        end else begin
                            n_action = ipv4lpm_pkg::ACT_UNKNOWN_PROTO;
                        end
                    end else if (!w_lookup) begin
                        n_done   = 1'b1;
                        n_action = ipv4lpm_pkg::ACT_TIME_EXCEEDED;
                    end else begin
                        n_state = ipv4lpm_pkg::ST_SEARCH;
                    end
                end
            end
            ipv4lpm_pkg::ST_SEARCH: begin
                if (w_tail.active) begin
                    n_state   = ipv4lpm_pkg::ST_IDLE;
                    n_done    = 1'b1;
                    n_new_ttl = r_ttl_dec;
                    if (w_tail.found) begin
                        n_action   = ipv4lpm_pkg::ACT_FORWARD;
                        n_next_hop = w_tail.gateway;
                        n_out_port = w_tail.port;
                    end else begin
                        n_action   = ipv4lpm_pkg::ACT_NET_UNREACH;
                        n_next_hop = 32'd0;
                        n_out_port = 2'd0;
                    end
                end
            end
            default: begin
                n_state = ipv4lpm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_done     = r_done;
    assign o_action   = r_action;
    assign o_new_ttl  = r_new_ttl;
    assign o_next_hop = r_next_hop;
    assign o_out_port = r_out_port;

endmodule

// File: hw/rtl/ipv4lpm_cell.sv
// One routing table slot of the match chain: holds a route entry and updates
// the passing search token. Depends on ipv4lpm_pkg.
`timescale 1ns / 1ps

module ipv4lpm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  ipv4lpm_pkg::t_route_entry i_entry,
    input  ipv4lpm_pkg::t_token       i_token,
    output ipv4lpm_pkg::t_token       o_token
);

    logic                r_valid;
    logic [31:0]         r_dest;
    logic [31:0]         r_mask;
    logic [31:0]         r_gateway;
    logic [1:0]          r_port;
    ipv4lpm_pkg::t_token r_token;
    ipv4lpm_pkg::t_token n_token;
    logic                w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_dest    <= i_entry.dest;
            r_mask    <= i_entry.mask;
            r_gateway <= i_entry.gateway;
            r_port    <= i_entry.port;
        end
    end

    assign w_hit = r_valid
                && ((r_dest & r_mask) == (i_token.dst & r_mask))
                && (r_mask >= i_token.best_mask);

    always_comb begin
        n_token = i_token;
        if (i_token.active && w_hit) begin
            n_token.found     = 1'b1;
            n_token.best_mask = r_mask;
            n_token.gateway   = r_gateway;
            n_token.port      = r_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token.active <= 1'b0;
        end else begin
            r_token.active <= n_token.active;
        end
        r_token.dst       <= n_token.dst;
        r_token.found     <= n_token.found;
        r_token.best_mask <= n_token.best_mask;
        r_token.gateway   <= n_token.gateway;
        r_token.port      <= n_token.port;
    end

    assign o_token = r_token;

endmodule
